/* rtl/pwra_pkg.sv */
// Shared constants, codes and control types of the page window run allocator.
`timescale 1ns / 1ps
package pwra_pkg;

  // Default geometry of the window
  localparam int WINDOW_PAGES_DEF = 1024;
  localparam int PAGE_SHIFT_DEF   = 12;

  // Bitmap word organisation
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  // Beat field widths
  localparam int ADDR_W   = 64;
  localparam int LEN_W    = 32;
  localparam int STATUS_W = 2;
  localparam int FIRST_W  = 10;
  localparam int COUNT_W  = 11;

  localparam logic [ADDR_W-1:0] BASE_RESET = 64'h0000_0000_E000_0000;

  // Request commands
  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_RUN  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                span;
    logic                check;
    logic                scan_init;
    logic                scan;
    logic                mark_init;
    logic                mark;
    logic                clear;
    logic                finish;
    logic [STATUS_W-1:0] res_code;
  } pwra_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic null_req;
    logic unmap;
    logic too_big;
    logic outside;
    logic hit;
    logic scan_fail;
    logic mark_done;
    logic out_free;
  } pwra_stat_t;

endpackage

/* rtl/pwra_req_if.sv */
// Request channel: command, address and byte length.
`timescale 1ns / 1ps
interface pwra_req_if;
  import pwra_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  byte_length;

  modport source (output valid, command, address, byte_length, input ready);
  modport sink   (input valid, command, address, byte_length, output ready);
endinterface

/* rtl/pwra_rsp_if.sv */
// Response channel: status, mapped address, first page and page count.
`timescale 1ns / 1ps
interface pwra_rsp_if;
  import pwra_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   mapped_address;
  logic [FIRST_W-1:0]  first_page;
  logic [COUNT_W-1:0]  page_count;

  modport source (output valid, status, mapped_address, first_page, page_count, input ready);
  modport sink   (input valid, status, mapped_address, first_page, page_count, output ready);
endinterface

/* rtl/pwra_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module pwra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pwra_dpath.sv */
// Datapath: request registers, span and window arithmetic, bitmap scan and marking,
// result register.
`timescale 1ns / 1ps
module pwra_dpath #(
  parameter int WINDOW_PAGES = pwra_pkg::WINDOW_PAGES_DEF,
  parameter int PAGE_SHIFT   = pwra_pkg::PAGE_SHIFT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pwra_pkg::ADDR_W-1:0]   cfg_data,
  input  logic                          in_command,
  input  logic [pwra_pkg::ADDR_W-1:0]   in_address,
  input  logic [pwra_pkg::LEN_W-1:0]    in_byte_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pwra_pkg::STATUS_W-1:0] out_status,
  output logic [pwra_pkg::ADDR_W-1:0]   out_mapped_address,
  output logic [pwra_pkg::FIRST_W-1:0]  out_first_page,
  output logic [pwra_pkg::COUNT_W-1:0]  out_page_count,
  input  pwra_pkg::pwra_cmd_t           cmd,
  output pwra_pkg::pwra_stat_t          stat
);
  import pwra_pkg::*;

  localparam int WORDS  = (WINDOW_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW     = AW + BIT_W;                   // page index incl. pad
  localparam int CW     = $clog2(WINDOW_PAGES + 1);     // page count
  localparam int TW     = CW + 1;                       // run length with carry
  localparam int EW     = ((XW > CW) ? XW : CW) + 1;    // run bound arithmetic
  localparam int SUM_W  = 34;
  localparam int PGS_W  = SUM_W - PAGE_SHIFT;
  localparam logic [AW-1:0]     LAST_WORD = AW'(WORDS - 1);
  localparam logic [SUM_W-1:0]  OFF_MASK  = (SUM_W'(1) << PAGE_SHIFT) - SUM_W'(1);
  localparam logic [ADDR_W-1:0] AMASK     = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);
  localparam logic [ADDR_W:0]   WIN_BYTES = (65'(WINDOW_PAGES)) << PAGE_SHIFT;

  // Configuration and request registers
  logic [ADDR_W-1:0] window_base;
  logic              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;

  // Span stage
  logic [PGS_W-1:0]  pages_r;
  logic              null_r;
  logic              below_r;
  logic [ADDR_W-1:0] diff_r;

  // Scan and mark sequencing
  logic [AW-1:0] rd_word;
  logic          rd_more;
  logic          pend;
  logic [AW-1:0] pend_word;
  logic [CW-1:0] carry;
  logic [XW-1:0] run_lo;
  logic [XW-1:0] run_hi;

  // RAM port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;

  // Combinational helpers
  logic [SUM_W-1:0]  span_sum;
  logic [ADDR_W:0]   diff_full;
  logic [31:0]       pages32;
  logic              too_big;
  logic [CW-1:0]     need;
  logic [CW-1:0]     sat_count;
  logic [ADDR_W:0]   end_bytes;
  logic              far;
  logic [EW-1:0]     unmap_hi;
  logic [5:0]        lvl [0:5][0:WORD_BITS-1];
  logic [TW-1:0]     tot [0:WORD_BITS-1];
  logic [WORD_BITS-1:0] hit_vec;
  logic              hit_any;
  logic [BIT_W-1:0]  hit_bit;
  logic [XW-1:0]     end_pg;
  logic [EW-1:0]     start_pg;
  logic [WORD_BITS-1:0] mask;
  logic [ADDR_W-1:0] map_off;
  logic [31:0]       first32;
  logic [31:0]       count32;

  pwra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_word),
    .rdata (ram_rdata)
  );

  // Span, null test and window offset
  assign span_sum  = SUM_W'(addr_r[PAGE_SHIFT-1:0]) + SUM_W'(len_r) + OFF_MASK;
  assign diff_full = {1'b0, addr_r & ~AMASK} - {1'b0, window_base};

  // Page count views
  assign pages32   = 32'(pages_r);
  assign too_big   = pages32 > 32'(WINDOW_PAGES);
  assign need      = pages32[CW-1:0];
  assign sat_count = too_big ? CW'(WINDOW_PAGES) : need;

  // Unmap window test; the end is taken one bit wider so it cannot wrap
  assign end_bytes = {1'b0, diff_r} + ((65'(pages_r)) << PAGE_SHIFT);
  assign far       = ({1'b0, diff_r} > WIN_BYTES) || (end_bytes > WIN_BYTES);
  assign unmap_hi  = EW'(diff_r[PAGE_SHIFT +: XW]) + EW'(need) - EW'(1);

  // Free run length ending at each bit, built by doubling over five levels
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      lvl[0][j] = (!ram_rdata[j] && (32'({pend_word, BIT_W'(j)}) < 32'(WINDOW_PAGES)))
                  ? 6'd1 : 6'd0;
    end
    for (int s = 0; s < 5; s++) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if ((j >= (1 << s)) && (lvl[s][j] == 6'(1 << s))) begin
          lvl[s+1][j] = lvl[s][j] + lvl[s][j - (1 << s)];
        end else begin
          lvl[s+1][j] = lvl[s][j];
        end
      end
    end
  end

  // Add the run carried in from lower words and test against the request
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lvl[5][j] == 6'(j + 1)) begin
        tot[j] = TW'(carry) + TW'(j + 1);
      end else begin
        tot[j] = TW'(lvl[5][j]);
      end
      hit_vec[j] = tot[j] >= {1'b0, need};
    end
  end

  // Lowest bit at which the run is long enough
  always_comb begin
    hit_bit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_bit = BIT_W'(j);
      end
    end
  end

  assign hit_any  = |hit_vec;
  assign end_pg   = {pend_word, hit_bit};
  assign start_pg = EW'(end_pg) + EW'(1) - EW'(need);

  // Bits of the current word inside [run_lo, run_hi]
  always_comb begin
    mask = '1;
    if (pend_word == run_lo[XW-1:BIT_W]) begin
      mask = mask & ({WORD_BITS{1'b1}} << run_lo[BIT_W-1:0]);
    end
    if (pend_word == run_hi[XW-1:BIT_W]) begin
      mask = mask & ({WORD_BITS{1'b1}} >> (~run_hi[BIT_W-1:0]));
    end
  end

  // RAM port selection: clearing pass or read-modify-write while marking
  always_comb begin
    ram_re    = (cmd.scan || cmd.mark) && rd_more;
    ram_we    = cmd.clear || (cmd.mark && pend);
    ram_waddr = cmd.clear ? rd_word : pend_word;
    if (cmd.clear) begin
      ram_wdata = '0;
    end else if (cmd_r == CMD_MAP) begin
      ram_wdata = ram_rdata | mask;
    end else begin
      ram_wdata = ram_rdata & ~mask;
    end
  end

  // Status towards the controller
  always_comb begin
    stat.clear_done = rd_word == LAST_WORD;
    stat.null_req   = null_r;
    stat.unmap      = cmd_r == CMD_UNMAP;
    stat.too_big    = too_big;
    stat.outside    = below_r || far;
    stat.hit        = pend && hit_any;
    stat.scan_fail  = pend && !hit_any && (pend_word == LAST_WORD);
    stat.mark_done  = pend && (pend_word == run_hi[XW-1:BIT_W]);
    stat.out_free   = !out_valid || out_ready;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= BASE_RESET;
    end else if (cfg_write) begin
      window_base <= cfg_data;
    end
  end

  // Request capture and span stage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      addr_r <= in_address;
      len_r  <= in_byte_length;
    end
    if (cmd.span) begin
      pages_r <= span_sum[SUM_W-1:PAGE_SHIFT];
      null_r  <= (len_r == '0) || ((cmd_r == CMD_UNMAP) && (addr_r == '0));
      below_r <= diff_full[ADDR_W];
      diff_r  <= diff_full[ADDR_W-1:0];
    end
  end

  // Word sequencing for the clearing pass, the scan and the marking pass
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_word <= '0;
      rd_more <= 1'b0;
      pend    <= 1'b0;
    end else if (cmd.clear) begin
      rd_word <= rd_word + AW'(1);
    end else if (cmd.scan_init) begin
      rd_word <= '0;
      rd_more <= 1'b1;
      pend    <= 1'b0;
    end else if (cmd.mark_init) begin
      rd_word <= run_lo[XW-1:BIT_W];
      rd_more <= 1'b1;
      pend    <= 1'b0;
    end else if (cmd.scan || cmd.mark) begin
      pend <= rd_more;
      if (rd_more) begin
        rd_word <= rd_word + AW'(1);
        rd_more <= cmd.scan ? (rd_word != LAST_WORD)
                            : (rd_word != run_hi[XW-1:BIT_W]);
      end
    end
  end

  // Word under processing, carried run and run bounds
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      carry <= '0;
    end else if (cmd.scan && pend && !hit_any) begin
      carry <= tot[WORD_BITS-1][CW-1:0];
    end
    if ((cmd.scan || cmd.mark) && rd_more) begin
      pend_word <= rd_word;
    end
    if (cmd.check) begin
      run_lo <= diff_r[PAGE_SHIFT +: XW];
      run_hi <= unmap_hi[XW-1:0];
    end else if (cmd.scan && pend && hit_any) begin
      run_lo <= start_pg[XW-1:0];
      run_hi <= end_pg;
    end
  end

  // Result register
  assign map_off = (ADDR_W'(run_lo) << PAGE_SHIFT) | ADDR_W'(addr_r[PAGE_SHIFT-1:0]);
  assign first32 = 32'(run_lo);
  assign count32 = 32'(sat_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= cmd.res_code;
      if ((cmd.res_code == ST_OK) && (cmd_r == CMD_MAP)) begin
        out_mapped_address <= window_base + map_off;
      end else begin
        out_mapped_address <= '0;
      end
      out_first_page <= (cmd.res_code == ST_OK) ? first32[FIRST_W-1:0] : '0;
      out_page_count <= (cmd.res_code == ST_NULL) ? '0 : count32[COUNT_W-1:0];
    end
  end

endmodule

/* rtl/pwra_ctrl.sv */
// Controller: sequences clearing, span, window check, scan, marking and result.
`timescale 1ns / 1ps
module pwra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output pwra_pkg::pwra_cmd_t  cmd,
  input  pwra_pkg::pwra_stat_t stat
);
  import pwra_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SPAN  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_MINIT = 3'd5;
  localparam logic [2:0] S_MARK  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [STATUS_W-1:0] res_code;
  logic [STATUS_W-1:0] res_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      res_code <= ST_OK;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.res_code  = res_code;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SPAN;
        end
      end
      S_SPAN: begin
        cmd.span   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.null_req) begin
          res_code_next = ST_NULL;
          state_next    = S_DONE;
        end else if (!stat.unmap) begin
          if (stat.too_big) begin
            res_code_next = ST_NO_RUN;
            state_next    = S_DONE;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end else if (stat.outside) begin
          res_code_next = ST_OUTSIDE;
          state_next    = S_DONE;
        end else begin
          state_next = S_MINIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_next = S_MINIT;
        end else if (stat.scan_fail) begin
          res_code_next = ST_NO_RUN;
          state_next    = S_DONE;
        end
      end
      S_MINIT: begin
        cmd.mark_init = 1'b1;
        state_next    = S_MARK;
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (stat.mark_done) begin
          res_code_next = ST_OK;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/page_window_run_allocator_unit.sv */
// Top level of the page window run allocator: controller, datapath and checks.
//
//  channel   dir  handshake                 beat
//  request   in   request.valid/ready       command, address, byte_length
//  response  out  response.valid/ready      status, mapped_address, first_page, page_count
//  cfg       in   cfg_write                 cfg_data -> window_base
//
//  One request at a time. Null requests and failed window checks pass the span, check and
//  done states to the result register; a map scans one 32-page bitmap word per cycle (up to
//  WINDOW_PAGES/32 words), then rewrites each word the run touches at one word per cycle.
//  The single read port and single write port of the bitmap RAM set this rate. After reset
//  a clearing pass writes zero to every bitmap word; request.ready stays low meanwhile. A
//  new request is taken while a result still waits in the output register; a stalled
//  result only holds up the next result.
`timescale 1ns / 1ps
module page_window_run_allocator_unit #(
  parameter int WINDOW_PAGES = pwra_pkg::WINDOW_PAGES_DEF,
  parameter int PAGE_SHIFT   = pwra_pkg::PAGE_SHIFT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [pwra_pkg::ADDR_W-1:0] cfg_data,
  pwra_req_if.sink                    request,
  pwra_rsp_if.source                  response
);
  import pwra_pkg::*;

  pwra_cmd_t  cmd;
  pwra_stat_t stat;
  logic       in_ready;

  assign request.ready = in_ready;

  pwra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  pwra_dpath #(
    .WINDOW_PAGES (WINDOW_PAGES),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data),
    .in_command         (request.command),
    .in_address         (request.address),
    .in_byte_length     (request.byte_length),
    .out_valid          (response.valid),
    .out_ready          (response.ready),
    .out_status         (response.status),
    .out_mapped_address (response.mapped_address),
    .out_first_page     (response.first_page),
    .out_page_count     (response.page_count),
    .cmd                (cmd),
    .stat               (stat)
  );

`ifndef ASSERT_OFF
  // An accepted request closes the input until its result is formed
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !request.ready)
    else $error("request accepted while another was in progress");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!response.valid || response.ready))
    else $error("result register overwritten");

  // A finished request is presented on the next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> response.valid)
    else $error("finished result not presented");

  // Datapath operations other than scan_init, which comes with check, are mutually exclusive
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.span, cmd.check, cmd.scan, cmd.mark_init, cmd.mark,
              cmd.clear, cmd.finish}))
    else $error("overlapping datapath commands");
`endif

endmodule
